/* hw/rtl/bracket_count_scanner_core_macros.svh */
// Assertion helpers shared by the RTL files.
`ifndef BRACKET_COUNT_SCANNER_CORE_MACROS_SVH
`define BRACKET_COUNT_SCANNER_CORE_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, checked outside reset
`define BCS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bcs assertion failed");

// Next-cycle implication, checked outside reset
`define BCS_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bcs assertion failed");

`else

`define BCS_ASSERT_IMP(label, clk, rst, ante, cons)
`define BCS_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

/* hw/rtl/bcs_pkg.sv */
`timescale 1ns / 1ps

package bcs_pkg;

  // Default bracket capacity and result count width
  localparam int unsigned SYMBOL_CAPACITY = 256;
  localparam int unsigned COUNT_W         = 9;
  localparam int unsigned NUM_KINDS       = 6;
  localparam int unsigned TDATA_OUT_W     = 64;

  // Characters the scanner reacts to
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_SQUOTE  = 8'h27;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_LCURLY  = 8'h7B;
  localparam logic [7:0] CH_RCURLY  = 8'h7D;
  localparam logic [7:0] CH_LSQUARE = 8'h5B;
  localparam logic [7:0] CH_RSQUARE = 8'h5D;
  localparam logic [7:0] CH_LROUND  = 8'h28;
  localparam logic [7:0] CH_RROUND  = 8'h29;

  // Scanner modes
  typedef enum logic [2:0] {
    SM_NORMAL      = 3'd0,
    SM_SLASH       = 3'd1,
    SM_LINE        = 3'd2,
    SM_BLOCK       = 3'd3,
    SM_BLOCK_STAR  = 3'd4,
    SM_STRING      = 3'd5,
    SM_LITERAL     = 3'd6,
    SM_LITERAL_END = 3'd7
  } scan_mode_t;

  // Which counter a byte bumps
  typedef enum logic [2:0] {
    BK_CURLY_OPEN   = 3'd0,
    BK_CURLY_CLOSE  = 3'd1,
    BK_SQUARE_OPEN  = 3'd2,
    BK_SQUARE_CLOSE = 3'd3,
    BK_ROUND_OPEN   = 3'd4,
    BK_ROUND_CLOSE  = 3'd5,
    BK_NONE         = 3'd6
  } bracket_t;

  // One result transaction
  typedef struct packed {
    logic               symbols_dropped;
    logic               round_match;
    logic               square_match;
    logic               curly_match;
    logic [COUNT_W-1:0] round_close_count;
    logic [COUNT_W-1:0] round_open_count;
    logic [COUNT_W-1:0] square_close_count;
    logic [COUNT_W-1:0] square_open_count;
    logic [COUNT_W-1:0] curly_close_count;
    logic [COUNT_W-1:0] curly_open_count;
  } scan_result_t;

  // Scanner status seen by the top level
  typedef struct packed {
    scan_mode_t mode;
    logic       cleared;
  } scan_stat_t;

endpackage

/* hw/rtl/bcs_scan.sv */
`timescale 1ns / 1ps

module bcs_scan import bcs_pkg::*; #(
  parameter int unsigned SymbolCapacity = SYMBOL_CAPACITY
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         step,
  input  logic [7:0]   text_byte,
  input  logic         last_byte,
  output scan_result_t result,
  output scan_stat_t   stat
);

  localparam int unsigned CntW = $clog2(SymbolCapacity + 1);
  localparam logic [CntW-1:0] CapV = CntW'(SymbolCapacity);

  scan_mode_t     mode;
  scan_mode_t     mode_next;
  scan_mode_t     norm_next;
  bracket_t       norm_kind;
  bracket_t       kind;
  logic [CntW-1:0] totals      [NUM_KINDS];
  logic [CntW-1:0] totals_next [NUM_KINDS];
  logic [CntW-1:0] symbol_total;
  logic [CntW-1:0] symbol_total_next;
  logic            dropped_seen;
  logic            dropped_next;

  // Low count bits, zero-extended when the totals are narrower
  function automatic logic [COUNT_W-1:0] low_count(input logic [CntW-1:0] t);
    logic [CntW+COUNT_W-1:0] ext;
    ext = {{COUNT_W{1'b0}}, t};
    return ext[COUNT_W-1:0];
  endfunction

  // Normal-text decode of one byte
  always_comb begin
    norm_next = SM_NORMAL;
    norm_kind = BK_NONE;
    unique case (text_byte)
      CH_SLASH:   norm_next = SM_SLASH;
      CH_DQUOTE:  norm_next = SM_STRING;
      CH_SQUOTE:  norm_next = SM_LITERAL;
      CH_LCURLY:  norm_kind = BK_CURLY_OPEN;
      CH_RCURLY:  norm_kind = BK_CURLY_CLOSE;
      CH_LSQUARE: norm_kind = BK_SQUARE_OPEN;
      CH_RSQUARE: norm_kind = BK_SQUARE_CLOSE;
      CH_LROUND:  norm_kind = BK_ROUND_OPEN;
      CH_RROUND:  norm_kind = BK_ROUND_CLOSE;
      default:    norm_kind = BK_NONE;
    endcase
  end

  // Mode next state
  always_comb begin
    mode_next = mode;
    unique case (mode)
      SM_NORMAL: mode_next = norm_next;
      SM_SLASH: begin
        if (text_byte == CH_SLASH) mode_next = SM_LINE;
        else if (text_byte == CH_STAR) mode_next = SM_BLOCK;
        else mode_next = SM_NORMAL;
      end
      SM_LINE: begin
        if (text_byte == CH_NEWLINE) mode_next = SM_NORMAL;
      end
      SM_BLOCK: begin
        if (text_byte == CH_STAR) mode_next = SM_BLOCK_STAR;
      end
      SM_BLOCK_STAR: begin
        if (text_byte == CH_SLASH) mode_next = SM_NORMAL;
        else if (text_byte != CH_STAR) mode_next = SM_BLOCK;
      end
      SM_STRING: begin
        if (text_byte == CH_DQUOTE) mode_next = SM_NORMAL;
      end
      SM_LITERAL: begin
        if (text_byte == CH_SQUOTE) mode_next = SM_LITERAL_END;
      end
      SM_LITERAL_END: begin
        if (text_byte == CH_SQUOTE) mode_next = SM_NORMAL;
        else mode_next = norm_next;
      end
      default: mode_next = SM_NORMAL;
    endcase
  end

  // Mode outputs: brackets count only in normal text
  always_comb begin
    kind = BK_NONE;
    unique case (mode)
      SM_NORMAL:      kind = norm_kind;
      SM_LITERAL_END: kind = (text_byte == CH_SQUOTE) ? BK_NONE : norm_kind;
      default:        kind = BK_NONE;
    endcase
  end

  // Counter update with capacity check
  always_comb begin
    symbol_total_next = symbol_total;
    dropped_next      = dropped_seen;
    for (int k = 0; k < NUM_KINDS; k++) begin
      totals_next[k] = totals[k];
    end
    if (kind != BK_NONE) begin
      if (symbol_total < CapV) begin
        symbol_total_next = symbol_total + 1'b1;
        for (int k = 0; k < NUM_KINDS; k++) begin
          if (kind == bracket_t'(3'(k))) totals_next[k] = totals[k] + 1'b1;
        end
      end else begin
        dropped_next = 1'b1;
      end
    end
  end

  // State registers; a last byte clears everything after it is scanned
  always_ff @(posedge clk) begin
    if (rst || (step && last_byte)) begin
      mode         <= SM_NORMAL;
      symbol_total <= '0;
      dropped_seen <= 1'b0;
      for (int k = 0; k < NUM_KINDS; k++) totals[k] <= '0;
    end else if (step) begin
      mode         <= mode_next;
      symbol_total <= symbol_total_next;
      dropped_seen <= dropped_next;
      for (int k = 0; k < NUM_KINDS; k++) totals[k] <= totals_next[k];
    end
  end

  // Result from the updated totals
  always_comb begin
    result.curly_open_count   = low_count(totals_next[BK_CURLY_OPEN]);
    result.curly_close_count  = low_count(totals_next[BK_CURLY_CLOSE]);
    result.square_open_count  = low_count(totals_next[BK_SQUARE_OPEN]);
    result.square_close_count = low_count(totals_next[BK_SQUARE_CLOSE]);
    result.round_open_count   = low_count(totals_next[BK_ROUND_OPEN]);
    result.round_close_count  = low_count(totals_next[BK_ROUND_CLOSE]);
    result.curly_match  = (totals_next[BK_CURLY_OPEN] == totals_next[BK_CURLY_CLOSE]);
    result.square_match = (totals_next[BK_SQUARE_OPEN] == totals_next[BK_SQUARE_CLOSE]);
    result.round_match  = (totals_next[BK_ROUND_OPEN] == totals_next[BK_ROUND_CLOSE]);
    result.symbols_dropped = dropped_next;
  end

  assign stat.mode    = mode;
  assign stat.cleared = (symbol_total == '0) && !dropped_seen;

endmodule

/* hw/rtl/bcs_out.sv */
`timescale 1ns / 1ps

module bcs_out import bcs_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  scan_result_t           result,
  input  logic                   m_axis_tready,
  output logic                   m_axis_tvalid,
  output logic [TDATA_OUT_W-1:0] m_axis_tdata
);

  localparam int unsigned ResW = $bits(scan_result_t);

  scan_result_t res_q;

  // Valid flag: set on load, dropped once the transaction is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // Payload register
  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= result;
    end
  end

  assign m_axis_tdata = {{(TDATA_OUT_W - ResW){1'b0}}, res_q};

endmodule

/* hw/rtl/bracket_count_scanner_core.sv */
`timescale 1ns / 1ps
// Channel   Dir  Payload                                     Handshake
// s_axis    in   tdata[7:0] text_byte, tlast last_byte       tvalid/tready
// m_axis    out  tdata[57:0] six counts, three matches, drop tvalid/tready
//
// One byte per cycle sustained unless a last byte stalls; a result reaches m_axis
// through the input register, then the scan logic into the result register.
// Reset (rst, synchronous) returns the scanner to normal text with zero counts.
// Only a last byte can stall: it waits in the input register while an earlier
// result is still held on m_axis, and the input side then deasserts tready.

module bracket_count_scanner_core import bcs_pkg::*; #(
  parameter int unsigned SymbolCapacity = SYMBOL_CAPACITY
) (
  input  logic                   clk,
  input  logic                   rst,
  // tdata: [7:0] text_byte
  input  logic [7:0]             s_axis_tdata,
  input  logic                   s_axis_tlast,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // tdata: [8:0] curly_open_count, [17:9] curly_close_count,
  //   [26:18] square_open_count, [35:27] square_close_count,
  //   [44:36] round_open_count, [53:45] round_close_count,
  //   [54] curly_match, [55] square_match, [56] round_match,
  //   [57] symbols_dropped, [63:58] zero
  output logic [TDATA_OUT_W-1:0] m_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready
);

  `include "bracket_count_scanner_core_macros.svh"

  logic         in_valid;
  logic [7:0]   in_byte;
  logic         in_last;
  logic         advance;
  logic         last_step;
  scan_result_t result;
  scan_stat_t   stat;

  // A held byte moves on unless it is a last byte and the result slot is busy
  assign advance       = in_valid && (!in_last || !m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign last_step     = advance && in_last;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  bcs_scan #(
    .SymbolCapacity(SymbolCapacity)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .text_byte (in_byte),
    .last_byte (in_last),
    .result    (result),
    .stat      (stat)
  );

  bcs_out u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (last_step),
    .result        (result),
    .m_axis_tready (m_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tdata  (m_axis_tdata)
  );

  // A scanned last byte always leaves a result behind
  `BCS_ASSERT_NXT(a_last_gives_result, clk, rst, last_step, m_axis_tvalid)
  // After a last byte the scanner is back in normal text with nothing counted
  `BCS_ASSERT_NXT(a_last_clears, clk, rst, last_step, stat.mode == SM_NORMAL && stat.cleared)
  // Input stalls only for a last byte blocked by a waiting result
  `BCS_ASSERT_IMP(a_stall_cause, clk, rst, !s_axis_tready,
                  in_valid && in_last && m_axis_tvalid && !m_axis_tready)

endmodule
